// ----- design/pcbp_pkg.sv -----
// Shared types and constants for the prefix code bit packer.
package pcbp_pkg;

  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 3;
  localparam int TAKE_W      = 4;
  localparam int CODE_W      = 32;
  localparam int SYMBOL_BITS = 8;
  localparam int LEN_IN_W    = 6;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]             func;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [CODE_W-1:0]      code_word;
    logic [LEN_IN_W-1:0]    code_length;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_req_t;

  // One pass of the bit extractor
  typedef struct packed {
    logic [BYTE_W-1:0] pending_next;
    logic [TAKE_W-1:0] take;
    logic              full;
  } chunk_res_t;

endpackage

// ----- design/pcbp_ram.sv -----
// Generic single-port RAM with registered read data.
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/pcbp_chunk.sv -----
// Shared bit extractor: moves up to one byte of code bits into the pending byte.
module pcbp_chunk import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic [CODE_W-1:0]                   code,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]   rem,
  input  logic [FILL_W-1:0]                   filled,
  input  logic [BYTE_W-1:0]                   pending,
  output chunk_res_t                          res
);

  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int SPAN_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int EXT_W  = SPAN_W + BYTE_W;
  localparam int CMP_W  = (LEN_W > TAKE_W) ? LEN_W : TAKE_W;

  logic [EXT_W-1:0]  ext;
  logic [BYTE_W-1:0] win;
  logic [BYTE_W-1:0] mask;
  logic [TAKE_W-1:0] free;
  logic              enough;

  always_comb begin
    // Code shifted up one byte so positions below zero read as zero padding
    ext    = EXT_W'(code) << BYTE_W;
    win    = BYTE_W'(ext >> rem);
    free   = TAKE_W'(BYTE_W) - TAKE_W'(filled);
    enough = CMP_W'(rem) >= CMP_W'(free);
    res.take = enough ? free : TAKE_W'(rem);
    res.full = enough;
    mask = {BYTE_W{1'b1}} << (TAKE_W'(BYTE_W) - res.take);
    res.pending_next = pending | ((win & mask) >> filled);
  end

endmodule

// ----- design/prefix_code_bit_packer.sv -----
// Top level: table-driven prefix code encoder packing code bits into bytes.
// A load request writes its table entry when accepted; a flush request moves the pending
// byte to the output register once it is free. An encode request reads the table, then
// makes one shared-extractor pass per byte the code touches (at most 5 for a 32-bit code).
// Throughput: one request at a time; in_ready is high only while the sequencer is idle.
// Reset (synchronous, active high) clears per-entry valid bits, the pending byte and fill.
module prefix_code_bit_packer import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int DEPTH   = 1 << SYMBOL_BITS;
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam int CMP_W   = (LEN_W > TAKE_W) ? LEN_W : TAKE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t             state;
  logic [DEPTH-1:0]   valid_bits;
  logic               look_valid;
  logic [CODE_W-1:0]  code_reg;
  logic [LEN_W-1:0]   rem;
  logic [BYTE_W-1:0]  pending;
  logic [FILL_W-1:0]  filled;

  logic               accept;
  logic               slot_free;
  logic               out_load;
  logic               ram_we;
  logic [LEN_W-1:0]   len_sat;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LEN_W-1:0]   rem_next;
  chunk_res_t         chunk;

  // Request handshake: take a request only while the sequencer is idle
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  // Output register can take a new byte when empty or draining this cycle
  assign slot_free = !out_valid || out_ready;
  // A byte enters the output register on a flush or a completed chunk
  assign out_load  = slot_free && ((state == S_FLUSH) || ((state == S_STEP) && chunk.full));

  // Saturate overlong lengths on load
  always_comb begin
    if (7'(in_data.code_length) > 7'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(in_data.code_length);
    end
  end

  assign ram_we    = accept && (in_data.func == FUNC_LOAD);
  assign ram_wdata = {len_sat, in_data.code_word};

  // Code table: one entry per symbol, code word in the low bits
  pcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (in_data.symbol),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Shared extractor, used once per byte the code touches
  pcbp_chunk #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_chunk (
    .code    (code_reg),
    .rem     (rem),
    .filled  (filled),
    .pending (pending),
    .res     (chunk)
  );

  assign rem_next = rem - LEN_W'(chunk.take);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      look_valid <= 1'b0;
      out_valid  <= 1'b0;
      pending    <= '0;
      filled     <= '0;
    end else begin
      // Load a new byte, or drop the current one once the consumer takes it
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.func)
              FUNC_LOAD: begin
                valid_bits[in_data.symbol] <= 1'b1;
              end
              FUNC_ENCODE: begin
                look_valid <= valid_bits[in_data.symbol];
                state      <= S_LOOK;
              end
              FUNC_FLUSH: begin
                state <= S_FLUSH;
              end
              default: begin
                // Unused function code: accept and ignore
              end
            endcase
          end
        end
        S_LOOK: begin
          // Table read data is ready: latch code and length, an unloaded entry has none
          code_reg <= ram_rdata[CODE_W-1:0];
          if (look_valid && (ram_rdata[ENTRY_W-1:CODE_W] != '0)) begin
            rem   <= ram_rdata[ENTRY_W-1:CODE_W];
            state <= S_STEP;
          end else begin
            rem   <= '0;
            state <= S_IDLE;
          end
        end
        S_STEP: begin
          // Advance one chunk; hold if it completes a byte and the output is busy
          if (!chunk.full || slot_free) begin
            rem <= rem_next;
            if (chunk.full) begin
              out_data.out_byte    <= chunk.pending_next;
              // Final byte of the request when no further full byte can follow
              out_data.last_of_run <= CMP_W'(rem_next) < CMP_W'(BYTE_W);
              pending              <= '0;
              filled               <= '0;
            end else begin
              pending <= chunk.pending_next;
              filled  <= FILL_W'(TAKE_W'(filled) + chunk.take);
            end
            if (rem_next == '0) begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_data.out_byte    <= pending;
            out_data.last_of_run <= 1'b1;
            pending              <= '0;
            filled               <= '0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Bits of the pending byte not yet filled stay clear
  a_pending_clear: assert property (@(posedge clk) disable iff (rst)
    (pending & ({BYTE_W{1'b1}} >> filled)) == '0)
    else $error("pending byte has bits set below the fill point");

  // The extractor only runs with code bits left
  a_step_has_bits: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (rem != '0))
    else $error("bit extraction running with no code bits left");

  // A lookup follows only an accepted encode request
  a_look_after_encode: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $past(accept && (in_data.func == FUNC_ENCODE)))
    else $error("table lookup without an encode request");

  // A flush leaves the packer empty with its byte in the output register
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FLUSH) && slot_free) |=>
      (filled == '0) && (pending == '0) && out_valid && out_data.last_of_run)
    else $error("flush did not empty the pending byte");

endmodule

// ----- sim/pcbp_byte_checker.sv -----
// Checker for the prefix code bit packer: mirrors the code table and compares packed bytes.
module pcbp_byte_checker import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_req_t out_data,
  output int       fail_count,
  output int       owed,
  output int       bytes_seen
);

  localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;

  logic [CODE_W-1:0]   code_bits [TABLE_DEPTH];
  logic [LEN_IN_W-1:0] code_len  [TABLE_DEPTH];
  logic [BYTE_W-1:0]   pend_byte;
  int                  pend_fill;
  out_req_t            bytes_due [$];

  // Work out the bytes one request releases and queue them in order
  task automatic predict_bytes(input in_req_t r);
    logic [BYTE_W-1:0] made [0:7];
    out_req_t          e;
    int                n;
    int                len;
    n = 0;
    case (r.func)
      FUNC_LOAD: begin
        code_bits[r.symbol] = r.code_word;
        code_len[r.symbol]  = (r.code_length > MAX_CODE_LEN) ?
                              LEN_IN_W'(MAX_CODE_LEN) : r.code_length;
      end
      FUNC_ENCODE: begin
        len = code_len[r.symbol];
        for (int i = len; i > 0; i--) begin
          if (i <= CODE_W && code_bits[r.symbol][i-1]) pend_byte[7 - pend_fill] = 1'b1;
          pend_fill++;
          if (pend_fill == BYTE_W) begin
            made[n]   = pend_byte;
            n++;
            pend_byte = '0;
            pend_fill = 0;
          end
        end
      end
      FUNC_FLUSH: begin
        made[0]   = pend_byte;
        n         = 1;
        pend_byte = '0;
        pend_fill = 0;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      e.out_byte    = made[k];
      e.last_of_run = (k == n - 1);
      bytes_due.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      foreach (code_len[s]) begin
        code_len[s]  = '0;
        code_bits[s] = '0;
      end
      pend_byte  = '0;
      pend_fill  = 0;
      bytes_due.delete();
      fail_count = 0;
      bytes_seen = 0;
    end else begin
      if (in_valid && in_ready) predict_bytes(in_data);
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (bytes_due.size() == 0) begin
          fail_count++;
          $error("unexpected byte: out_byte %02h last_of_run %0b",
                 out_data.out_byte, out_data.last_of_run);
        end else begin
          want = bytes_due.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            fail_count++;
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            fail_count++;
            $error("last_of_run: expected %0b, got %0b",
                   want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
    owed = bytes_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the prefix code bit packer: drives requests and gives the verdict.
module tb_top;
  import pcbp_pkg::*;

  localparam int         MAX_CODE_LEN = 32;
  // Watchdog limit, with a wide margin over the longest run
  localparam int         CYCLE_LIMIT  = 400000;
  // Drain margin: the longest encode is a table lookup plus 5 extractor passes
  localparam int         TAIL_CYCLES  = 16;
  localparam int         PHASE_REQS   = 77;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;

  int fail_count;
  int owed;
  int bytes_seen;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int sent [4]      = '{0, 0, 0, 0};

  prefix_code_bit_packer #(.MAX_CODE_LEN(MAX_CODE_LEN)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The checker sits beside the block, watches both channels and counts failures
  pcbp_byte_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .owed       (owed),
    .bytes_seen (bytes_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure: stall at the rate the current phase asks for
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_req_t req_of(input logic [1:0] func, input logic [7:0] sym,
                                     input logic [31:0] word, input logic [5:0] len);
    in_req_t r;
    r.func        = func;
    r.symbol      = sym;
    r.code_word   = word;
    r.code_length = len;
    return r;
  endfunction

  // Present one request, idling first at the phase's rate, and hold it until taken.
  // Always returns at a rising edge, straight after the accepting one.
  task automatic send_req(input in_req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    sent[r.func]++;
    // Sample ready away from the edge, then let the accepting edge pass
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          roll;
    logic [1:0]  func;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling on either side
    send_req(req_of(FUNC_ENCODE, 8'h00, 32'h0, 6'd0));          // never loaded: no bytes
    send_req(req_of(FUNC_FLUSH,  8'h00, 32'h0, 6'd0));          // flush of an empty byte
    send_req(req_of(FUNC_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32)); // longest code, all ones
    send_req(req_of(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0));          // four whole bytes
    send_req(req_of(FUNC_LOAD,   8'h01, 32'h0000_0001, 6'd1));  // single-bit code
    send_req(req_of(FUNC_ENCODE, 8'h01, 32'h0, 6'd0));
    send_req(req_of(FUNC_ENCODE, 8'h01, 32'h0, 6'd0));
    send_req(req_of(FUNC_ENCODE, 8'h01, 32'h0, 6'd0));
    send_req(req_of(FUNC_FLUSH,  8'h00, 32'h0, 6'd0));          // partial byte, zero padded
    send_req(req_of(FUNC_LOAD,   8'h02, 32'hAAAA_AAAA, 6'd63)); // overlong length saturates
    send_req(req_of(FUNC_ENCODE, 8'h02, 32'h0, 6'd0));
    send_req(req_of(FUNC_LOAD,   8'h80, 32'hDEAD_BEEF, 6'd33)); // just over the limit
    send_req(req_of(FUNC_ENCODE, 8'h80, 32'h0, 6'd0));
    send_req(req_of(FUNC_LOAD,   8'h03, 32'h0000_0005, 6'd3));
    send_req(req_of(FUNC_ENCODE, 8'h03, 32'h0, 6'd0));          // leaves three bits pending
    send_req(req_of(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0));          // straddles byte boundaries
    send_req(req_of(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F)); // unused code: ignore
    send_req(req_of(FUNC_LOAD,   8'h04, 32'h0001_2345, 6'd0));  // zero length: emits nothing
    send_req(req_of(FUNC_ENCODE, 8'h04, 32'h0, 6'd0));
    send_req(req_of(FUNC_LOAD,   8'h7F, 32'h0000_0001, 6'd32)); // long run of leading zeros
    send_req(req_of(FUNC_ENCODE, 8'h7F, 32'h0, 6'd0));
    send_req(req_of(FUNC_LOAD,   8'h00, 32'h0, 6'd0));
    send_req(req_of(FUNC_FLUSH,  8'h00, 32'h0, 6'd0));

    // Random part in four idling phases: none, sender only, receiver only, both
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 61 : (p == 3) ? 22 : 0;
      stall_pct     = (p == 2) ? 61 : (p == 3) ? 22 : 0;
      for (int k = 0; k < PHASE_REQS; k++) begin
        pick = $urandom_range(0, 99);
        // Favour a small alphabet so most encodes hit a loaded entry
        sym  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 255));
        word = $urandom;
        roll = $urandom_range(0, 9);
        len  = (roll == 0) ? 6'd0 :
               (roll == 1) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(1, 32));
        if (pick < 25)      func = FUNC_LOAD;
        else if (pick < 85) func = FUNC_ENCODE;
        else if (pick < 95) func = FUNC_FLUSH;
        else                func = FUNC_UNUSED;
        send_req(req_of(func, sym, word, len));
      end
      // Once, hold the sender back until the packer has drained completely
      if (p == 1) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (owed != 0);
        @(posedge clk);
      end
    end

    // Drop valid, release the receiver and drain what is still owed
    in_valid  <= 1'b0;
    stall_pct = 0;
    do @(negedge clk); while (owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d encodes, %0d flushes and %0d unused-code requests",
             sent[FUNC_LOAD], sent[FUNC_ENCODE], sent[FUNC_FLUSH], sent[FUNC_UNUSED]);
    $display("across four idling phases; %0d packed bytes compared", bytes_seen);
    if (fail_count == 0 && owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pcbp_pkg.sv
design/pcbp_ram.sv
design/pcbp_chunk.sv
design/prefix_code_bit_packer.sv
sim/pcbp_byte_checker.sv
sim/tb_top.sv
